[hw/rtl/ffds_pkg.sv]
// ----------------------------------------------------------------------------
// ffds_pkg
// Shared types and constants for the queue with drain-and-sum.
// ----------------------------------------------------------------------------
package ffds_pkg;

  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 16;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int REQ_W   = 8;
  localparam int TOTAL_W = 21;
  localparam int TAKEN_W = 6;
  localparam int CMP_W   = (CNT_W > REQ_W) ? CNT_W : REQ_W;

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                  kind;
    logic [DATA_WIDTH-1:0] item_value;
    logic [REQ_W-1:0]      request_count;
  } req_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [TAKEN_W-1:0] taken;
    logic [1:0]         status;
  } rsp_t;

endpackage

[hw/rtl/ffds_ram.sv]
// ----------------------------------------------------------------------------
// ffds_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/fifo_with_drain_sum_top.sv]
// ----------------------------------------------------------------------------
// fifo_with_drain_sum_top
// Ring-buffer queue: a push appends a word, a drain removes up to the
// requested number of oldest words and returns their sum and count.
// ----------------------------------------------------------------------------
//   channel   handshake               word
//   req       req_valid / req_ready   req_t: kind, item_value, request_count
//   rsp       rsp_valid / rsp_ready   rsp_t: total, taken, status
//
// A push, or a drain that removes nothing, is answered from the request
// straight into the output register when it is free, else held in S_HOLD.
// A drain of n words holds the input through the accepting cycle, the n
// reads, the summing of the last read data, the exit from the drain and
// the load of the output register.
// Reset (synchronous, active high) empties the queue; the RAM is not cleared.
// A new request is taken while the previous result waits in the output
// register; apart from a drain, the block only stalls when a second result
// would have no place.
// ----------------------------------------------------------------------------
module fifo_with_drain_sum_top
  import ffds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DRAIN = 3'b010,
    S_HOLD  = 3'b100
  } state_t;

  function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p);
    next_ptr = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t              state;
  logic [ADDR_W-1:0]   head;
  logic [ADDR_W-1:0]   tail;
  logic [CNT_W-1:0]    occupancy;
  logic [CNT_W-1:0]    left;
  logic                rd_pend;
  rsp_t                pend;

  logic                accept;
  logic                out_free;
  logic                full;
  logic                go_drain;
  logic [CMP_W-1:0]    want_ext;
  logic [CMP_W-1:0]    occ_ext;
  logic [CNT_W-1:0]    take_n;
  rsp_t                imm;
  logic                wr_en;
  logic                rd_en;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                rsp_load;
  rsp_t                rsp_data;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign full      = (occupancy == CNT_W'(DEPTH));

  assign want_ext = CMP_W'(req.request_count);
  assign occ_ext  = CMP_W'(occupancy);
  assign take_n   = (want_ext < occ_ext) ? CNT_W'(want_ext) : occupancy;
  assign go_drain = (req.kind == KIND_DRAIN) && (occupancy != '0)
                    && (req.request_count != '0);

  always_comb begin
    imm        = '0;
    imm.status = ST_OK;
    wr_en      = 1'b0;
    if (req.kind == KIND_PUSH) begin
      if (full) begin
        imm.status = ST_FULL;
      end else begin
        wr_en = accept;
      end
    end else if (occupancy == '0) begin
      imm.status = ST_EMPTY;
    end
  end

  // The output register takes a finished word straight from the request or
  // from the held result.
  always_comb begin
    rsp_load = 1'b0;
    rsp_data = imm;
    if (state == S_HOLD) begin
      rsp_load = out_free;
      rsp_data = pend;
    end else if (state == S_IDLE) begin
      rsp_load = accept && !go_drain && out_free;
    end
  end

  // Reads walk the head forward; the data for each is summed in the cycle after its read.
  assign rd_en = (state == S_DRAIN) && (left != '0);

  ffds_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (req.item_value),
    .rd_en   (rd_en),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      left      <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (rsp_load) begin
        rsp       <= rsp_data;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.kind == KIND_PUSH && !full) begin
              tail      <= next_ptr(tail);
              occupancy <= occupancy + 1'b1;
            end
            if (go_drain) begin
              occupancy   <= occupancy - take_n;
              left        <= take_n;
              pend.total  <= '0;
              pend.taken  <= TAKEN_W'(take_n);
              pend.status <= ST_OK;
              state       <= S_DRAIN;
            end else if (!out_free) begin
              pend  <= imm;
              state <= S_HOLD;
            end
          end
        end
        S_DRAIN: begin
          if (rd_en) begin
            head <= next_ptr(head);
            left <= left - 1'b1;
          end
          if (rd_pend) begin
            pend.total <= pend.total + TOTAL_W'(rd_data);
          end
          if (!rd_en && !rd_pend) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(DEPTH))
    else $error("occupancy exceeds the ring depth");

  a_read_origin: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state == S_DRAIN))
    else $error("read data pending outside a drain");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (left == '0 && !rd_pend))
    else $error("drain work left over on return to idle");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (accept && req.kind == KIND_PUSH && full)
      |=> (occupancy == $past(occupancy) && tail == $past(tail)))
    else $error("push into a full queue changed the queue");
`endif

endmodule
